// ===== hdl/sira_pkg.sv =====
package sira_pkg;

  // Default width of the signed value
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned OUT_W    = 8;
  // Quotient bits produced per divider cycle
  localparam int unsigned STEP_BITS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef struct packed {
    logic               bad_radix;
    logic               minus;
    logic [RADIX_W-1:0] radix;
  } item_flags_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DIGIT_TEN) begin
      c = CHAR_ALPHA + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ===== hdl/signed_integer_to_radix_ascii_top.sv =====
// Flow: an accepted word goes through the queue to the sequencer, which divides out each digit in turn;
//   the divider resolves 4 quotient bits per cycle. The characters then go out, most significant first.
// The sequencer converts one word at a time and pops the next only after the last character of the
//   current word is in the output register. A 2-word queue lets input run ahead.
// Reset: rst_ni asynchronous, active low; clears queue pointers, sequencer and output valid.
module signed_integer_to_radix_ascii_top #(
  parameter int unsigned VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: value [VALUE_BITS-1:0], radix [VALUE_BITS+4:VALUE_BITS], zero pad
  input  logic [((VALUE_BITS + sira_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                                                       s_axis_tvalid,
  output logic                                                       s_axis_tready,
  // tdata: character [6:0], zero [7]
  output logic [sira_pkg::OUT_W-1:0]                                 m_axis_tdata,
  output logic                                                       m_axis_tvalid,
  input  logic                                                       m_axis_tready,
  output logic                                                       m_axis_tlast,
  // tuser: bad_radix [0]
  output logic                                                       m_axis_tuser
);
  import sira_pkg::*;

  logic                  push, full, pop, empty;
  logic [VALUE_BITS-1:0] push_mag, pop_mag;
  item_flags_t           push_flags, pop_flags;
  logic [CHAR_W-1:0]     out_char;

  sira_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .value_i       (s_axis_tdata[VALUE_BITS-1:0]),
    .radix_i       (s_axis_tdata[VALUE_BITS +: RADIX_W]),
    .full_i        (full),
    .push_o        (push),
    .push_mag_o    (push_mag),
    .push_flags_o  (push_flags)
  );

  sira_fifo #(.VALUE_BITS(VALUE_BITS)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_mag_i   (push_mag),
    .push_flags_i (push_flags),
    .full_o       (full),
    .pop_i        (pop),
    .pop_mag_o    (pop_mag),
    .pop_flags_o  (pop_flags),
    .empty_o      (empty)
  );

  sira_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_mag_i     (pop_mag),
    .pop_flags_i   (pop_flags),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .char_o        (out_char),
    .last_o        (m_axis_tlast),
    .bad_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_W - CHAR_W)'(0), out_char};

endmodule

// ===== hdl/sira_front.sv =====
module sira_front #(
  parameter int unsigned VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [VALUE_BITS-1:0]          value_i,
  input  logic [sira_pkg::RADIX_W-1:0]   radix_i,
  input  logic                           full_i,
  output logic                           push_o,
  output logic [VALUE_BITS-1:0]          push_mag_o,
  output sira_pkg::item_flags_t          push_flags_o
);
  import sira_pkg::*;

  logic neg;

  assign neg           = value_i[VALUE_BITS-1];
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // Two's complement magnitude; the most negative value maps to 2^(N-1)
  assign push_mag_o = neg ? (~value_i + VALUE_BITS'(1)) : value_i;

  always_comb begin
    push_flags_o.bad_radix = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);
    push_flags_o.minus     = neg && (radix_i == RADIX_DEC);
    push_flags_o.radix     = radix_i;
  end

endmodule

// ===== hdl/sira_fifo.sv =====
module sira_fifo #(
  parameter int unsigned VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [VALUE_BITS-1:0] push_mag_i,
  input  sira_pkg::item_flags_t push_flags_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic [VALUE_BITS-1:0] pop_mag_o,
  output sira_pkg::item_flags_t pop_flags_o,
  output logic                  empty_o
);
  import sira_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] mag_q   [QUEUE_DEPTH];
  item_flags_t           flags_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_mag_o   = mag_q[rd_ptr_q];
  assign pop_flags_o = flags_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mag_q[wr_ptr_q]   <= push_mag_i;
      flags_q[wr_ptr_q] <= push_flags_i;
    end
  end

endmodule

// ===== hdl/sira_back.sv =====
module sira_back #(
  parameter int unsigned VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  logic [VALUE_BITS-1:0]         pop_mag_i,
  input  sira_pkg::item_flags_t         pop_flags_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sira_pkg::CHAR_W-1:0]   char_o,
  output logic                          last_o,
  output logic                          bad_o
);
  import sira_pkg::*;

  localparam int unsigned STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W  = STEPS * STEP_BITS;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned IDX_W  = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_SIGN = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_BAD  = 6'b100000
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [PAD_W-1:0]     mag_q, mag_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 minus_q, minus_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic [DIGIT_W-1:0]   digit_store [VALUE_BITS];
  logic [DIGIT_W-1:0]   rd_q;
  logic                 wr_en;

  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_bad_q, out_bad_d;
  logic                 out_free;

  // Divider datapath: STEP_BITS restoring steps per cycle
  logic [PAD_W-1:0]     div_mag;
  logic [DIGIT_W-1:0]   div_rem;
  logic [RADIX_W-1:0]   trial;

  always_comb begin
    div_mag = mag_q;
    div_rem = rem_q;
    trial   = '0;
    for (int k = 0; k < int'(STEP_BITS); k++) begin
      trial   = {div_rem, div_mag[PAD_W-1]};
      div_mag = {div_mag[PAD_W-2:0], 1'b0};
      if (trial >= radix_q) begin
        trial      = trial - radix_q;
        div_mag[0] = 1'b1;
      end
      div_rem = trial[DIGIT_W-1:0];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    minus_d     = minus_q;
    radix_d     = radix_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (pop_flags_i.bad_radix) begin
            state_d = ST_BAD;
          end else begin
            mag_d   = PAD_W'(pop_mag_i);
            rem_d   = '0;
            step_d  = '0;
            cnt_d   = '0;
            minus_d = pop_flags_i.minus;
            radix_d = pop_flags_i.radix;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_d = div_mag;
        rem_d = div_rem;
        if (step_q == STEP_W'(STEPS - 1)) begin
          // Digit complete: store remainder, restart on the quotient
          wr_en  = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          rem_d  = '0;
          step_d = '0;
          if (div_mag == '0) begin
            state_d = ST_PREP;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_PREP: begin
        rd_idx_d = IDX_W'(cnt_q - CNT_W'(1));
        state_d  = minus_q ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          out_bad_d   = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(rd_q);
          out_last_d  = (rd_idx_q == '0);
          out_bad_d   = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - IDX_W'(1);
          end
        end
      end
      ST_BAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_NONE;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  // Digit memory, least significant digit first
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_store[cnt_q[IDX_W-1:0]] <= div_rem;
    end
    rd_q <= digit_store[rd_idx_d];
  end

  assign m_axis_tvalid = out_valid_q;
  assign char_o        = out_char_q;
  assign last_o        = out_last_q;
  assign bad_o         = out_bad_q;

endmodule

// ===== hdl/sira_checker.sv =====
module sira_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic [sira_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic                        m_axis_tlast,
  input logic                        m_axis_tuser
);
  import sira_pkg::*;

  logic [CHAR_W-1:0] ch;
  assign ch = m_axis_tdata[CHAR_W-1:0];

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // A bad radix gives a lone zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("bad radix word malformed");

  // Only sign, decimal digits or A-F appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (ch == CHAR_MINUS)
      || ((ch >= CHAR_ZERO) && (ch <= CHAR_ZERO + 7'd9))
      || ((ch >= CHAR_ALPHA) && (ch <= CHAR_ALPHA + 7'd5)))
    else $error("illegal character");

  // A minus sign is never marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && (ch == CHAR_MINUS) |-> !m_axis_tlast)
    else $error("minus sign marked last");

endmodule

bind signed_integer_to_radix_ascii_top sira_checker u_sira_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
